### src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: quaternion to Euler angle converter shared definitions
// Widths, angle constants, arctangent table and rounding for RTL and checker.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQ_STEPS      = 29;
    localparam int XW            = 38;
    localparam int ZW            = 28;
    localparam int SW            = 35;
    localparam int RW            = 33;
    localparam int QW            = 29;
    localparam int RADW          = 58;
    localparam int SHW           = 5;

    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [SW-1:0] ONE_Q28     = 35'sd268435456;

    typedef struct packed {
        logic signed [SW-1:0] ay;
        logic signed [SW-1:0] ax;
        logic signed [SW-1:0] by;
        logic signed [SW-1:0] bx;
        logic signed [SW-1:0] s;
        logic                 flag;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [SHW-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            5'd20:   r = 28'sd16;
            5'd21:   r = 28'sd8;
            5'd22:   r = 28'sd4;
            5'd23:   r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q24 to Q3.13, round half up
    function automatic logic [15:0] round_q13(input logic signed [ZW-1:0] v);
        logic signed [ZW-1:0] sum;
        logic signed [ZW-1:0] sh;
        sum = v + ZW'(1024);
        sh  = sum >>> 11;
        return sh[15:0];
    endfunction

endpackage

### src/qte_in_if.sv
// ----------------------------------------------------------------------------
// qte_in_if: quaternion input channel
// Valid/ready channel carrying one Q2.14 quaternion per beat.
// ----------------------------------------------------------------------------
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### src/qte_out_if.sv
// ----------------------------------------------------------------------------
// qte_out_if: Euler angle output channel
// Valid/ready beats: Q3.13 first and last, Q2.13 middle angle, gimbal flag.
// ----------------------------------------------------------------------------
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_angle;
    logic signed [14:0] middle_angle;
    logic signed [15:0] last_angle;
    logic               gimbal_clamped;

    modport source (output valid, first_angle, middle_angle, last_angle, gimbal_clamped,
                    input ready);
    modport sink   (input valid, first_angle, middle_angle, last_angle, gimbal_clamped,
                    output ready);
endinterface

### src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one digit of the integer square root chain
// Takes two radicand bits, yields one root bit, carries the side payload.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [qte_pkg::RW-1:0]   i_rem,
    input  logic [qte_pkg::QW-1:0]   i_root,
    input  logic [qte_pkg::RADW-1:0] i_rad,
    input  qte_pkg::t_side           i_side,
    output logic [qte_pkg::RW-1:0]   o_rem,
    output logic [qte_pkg::QW-1:0]   o_root,
    output logic [qte_pkg::RADW-1:0] o_rad,
    output qte_pkg::t_side           o_side
);
    import qte_pkg::*;

    logic [RW-1:0]   w_rem_sh;
    logic [RW-1:0]   w_trial;
    logic [RW-1:0]   n_rem;
    logic [QW-1:0]   n_root;
    logic [RW-1:0]   r_rem;
    logic [QW-1:0]   r_root;
    logic [RADW-1:0] r_rad;
    t_side           r_side;

    always_comb begin
        w_rem_sh = {i_rem[RW-3:0], i_rad[RADW-1:RADW-2]};
        w_trial  = RW'({i_root, 2'b01});
        if (w_rem_sh >= w_trial) begin
            n_rem  = w_rem_sh - w_trial;
            n_root = {i_root[QW-2:0], 1'b1};
        end else begin
            n_rem  = w_rem_sh;
            n_root = {i_root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[RADW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_side = r_side;
endmodule

### src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward y = 0 by atan(2^-i); holds still once y is exactly zero.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [qte_pkg::SHW-1:0]       i_shift,
    input  logic signed [qte_pkg::XW-1:0] i_x,
    input  logic signed [qte_pkg::XW-1:0] i_y,
    input  logic signed [qte_pkg::ZW-1:0] i_z,
    output logic signed [qte_pkg::XW-1:0] o_x,
    output logic signed [qte_pkg::XW-1:0] o_y,
    output logic signed [qte_pkg::ZW-1:0] o_z
);
    import qte_pkg::*;

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_at;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    always_comb begin
        w_xs = i_x >>> i_shift;
        w_ys = i_y >>> i_shift;
        w_at = atan_q24(i_shift);
        if (i_y > 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_at;
        end else if (i_y < 0) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_at;
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

### src/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: unit quaternion to three Euler angles
// Q2.14 quaternion in, Q3.13/Q2.13 radians out, ZYX or YZX by mode register.
// ----------------------------------------------------------------------------
// One beat in and one beat out per clock when the sink keeps ready high.
// The pipeline is the input, product, sum and square registers, 29 cells
// of the square root chain for the middle cosine, a setup register, one
// cell per CORDIC stage and an output register. The whole chain stalls
// together while a result waits. Write the mode only when the block is
// empty; it is sampled with each input beat.
module quaternion_to_euler_angles (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data,
    qte_in_if.sink   i_in,
    qte_out_if.source o_out
);
    import qte_pkg::*;

    localparam int SQ0   = 4;
    localparam int PREP  = SQ0 + SQ_STEPS;
    localparam int CS0   = PREP + 1;
    localparam int NSTG  = CS0 + CORDIC_STAGES + 1;

    logic w_en;
    logic r_mode;
    logic r_vld [0:NSTG-1];

    assign w_en       = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // input register
    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic               r_m0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w  <= i_in.quat_w;
            r_x  <= i_in.quat_x;
            r_y  <= i_in.quat_y;
            r_z  <= i_in.quat_z;
            r_m0 <= r_mode;
        end
    end

    // products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic               r_m1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx <= r_w * r_x;
            r_yz <= r_y * r_z;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_wy <= r_w * r_y;
            r_zx <= r_z * r_x;
            r_wz <= r_w * r_z;
            r_xy <= r_x * r_y;
            r_zz <= r_z * r_z;
            r_m1 <= r_m0;
        end
    end

    // product sums, magnitude of s and its square
    t_side              n_side2;
    logic signed [SW-1:0] w_abs;
    t_side              r_side2;
    logic [27:0]        r_mag;
    t_side              r_side3;
    logic [55:0]        r_sq;

    always_comb begin
        if (!r_m1) begin
            n_side2.ay = (SW'(r_wx) + SW'(r_yz)) <<< 1;
            n_side2.ax = ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
            n_side2.s  = (SW'(r_wy) - SW'(r_zx)) <<< 1;
            n_side2.by = (SW'(r_wz) + SW'(r_xy)) <<< 1;
            n_side2.bx = ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        end else begin
            n_side2.ay = (SW'(r_wy) + SW'(r_zx)) <<< 1;
            n_side2.ax = ONE_Q28 - ((SW'(r_yy) + SW'(r_xx)) <<< 1);
            n_side2.s  = (SW'(r_wz) - SW'(r_xy)) <<< 1;
            n_side2.by = (SW'(r_wx) + SW'(r_yz)) <<< 1;
            n_side2.bx = ONE_Q28 - ((SW'(r_xx) + SW'(r_zz)) <<< 1);
        end
        n_side2.flag = (n_side2.s >= ONE_Q28) || (n_side2.s <= -ONE_Q28);
        w_abs = n_side2.s[SW-1] ? -n_side2.s : n_side2.s;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side2 <= n_side2;
            r_mag   <= w_abs[27:0];
            r_side3 <= r_side2;
            r_sq    <= r_mag * r_mag;
        end
    end

    // square root chain: c = isqrt(2^56 - s^2)
    logic [RW-1:0]   w_rem  [0:SQ_STEPS];
    logic [QW-1:0]   w_root [0:SQ_STEPS];
    logic [RADW-1:0] w_rad  [0:SQ_STEPS];
    t_side           w_side [0:SQ_STEPS];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = {2'b01, 56'd0} - {2'b00, r_sq};
    assign w_side[0] = r_side3;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .i_rad  (w_rad[g]),
            .i_side (w_side[g]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1]),
            .o_rad  (w_rad[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // CORDIC setup: lane 0 first angle, lane 1 middle, lane 2 last
    t_side                w_sq;
    logic signed [XW-1:0] w_px [0:2];
    logic signed [XW-1:0] w_py [0:2];
    logic signed [XW-1:0] n_px [0:2];
    logic signed [XW-1:0] n_py [0:2];
    logic signed [ZW-1:0] n_pz [0:2];
    logic signed [XW-1:0] r_px [0:2];
    logic signed [XW-1:0] r_py [0:2];
    logic signed [ZW-1:0] r_pz [0:2];
    logic                 r_flag [0:CORDIC_STAGES];
    logic                 r_sneg [0:CORDIC_STAGES];

    assign w_sq = w_side[SQ_STEPS];

    always_comb begin
        w_px[0] = XW'(w_sq.ax);
        w_py[0] = XW'(w_sq.ay);
        w_px[1] = XW'(w_root[SQ_STEPS]);
        w_py[1] = XW'(w_sq.s);
        w_px[2] = XW'(w_sq.bx);
        w_py[2] = XW'(w_sq.by);
        for (int l = 0; l < 3; l++) begin
            if (w_px[l] < 0) begin
                n_px[l] = -w_px[l];
                n_py[l] = -w_py[l];
                n_pz[l] = (w_py[l] >= 0) ? PI_Q24 : -PI_Q24;
            end else begin
                n_px[l] = w_px[l];
                n_py[l] = w_py[l];
                n_pz[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_px[l] <= n_px[l];
                r_py[l] <= n_py[l];
                r_pz[l] <= n_pz[l];
            end
            r_flag[0] <= w_sq.flag;
            r_sneg[0] <= w_sq.s[SW-1];
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_flag[k] <= r_flag[k-1];
                r_sneg[k] <= r_sneg[k-1];
            end
        end
    end

    logic signed [XW-1:0] w_cx [0:CORDIC_STAGES][0:2];
    logic signed [XW-1:0] w_cy [0:CORDIC_STAGES][0:2];
    logic signed [ZW-1:0] w_cz [0:CORDIC_STAGES][0:2];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_cx[0][l] = r_px[l];
        assign w_cy[0][l] = r_py[l];
        assign w_cz[0][l] = r_pz[l];
        for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
            qte_cordic_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_shift (SHW'(g)),
                .i_x     (w_cx[g][l]),
                .i_y     (w_cy[g][l]),
                .i_z     (w_cz[g][l]),
                .o_x     (w_cx[g+1][l]),
                .o_y     (w_cy[g+1][l]),
                .o_z     (w_cz[g+1][l])
            );
        end
    end

    // clamp, round, output register
    logic signed [ZW-1:0] w_za, w_zm, w_zb;
    logic [15:0]          w_qa, w_qm, w_qb;
    logic [15:0]          r_first, r_last;
    logic [14:0]          r_mid;
    logic                 r_gimbal;

    always_comb begin
        w_za = w_cz[CORDIC_STAGES][0];
        w_zm = w_cz[CORDIC_STAGES][1];
        w_zb = w_cz[CORDIC_STAGES][2];
        if (w_za > PI_Q24) w_za = PI_Q24;
        else if (w_za < -PI_Q24) w_za = -PI_Q24;
        if (w_zb > PI_Q24) w_zb = PI_Q24;
        else if (w_zb < -PI_Q24) w_zb = -PI_Q24;
        if (r_flag[CORDIC_STAGES]) w_zm = r_sneg[CORDIC_STAGES] ? -HALF_PI_Q24 : HALF_PI_Q24;
        else if (w_zm > HALF_PI_Q24) w_zm = HALF_PI_Q24;
        else if (w_zm < -HALF_PI_Q24) w_zm = -HALF_PI_Q24;
        w_qa = round_q13(w_za);
        w_qm = round_q13(w_zm);
        w_qb = round_q13(w_zb);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_first  <= w_qa;
            r_mid    <= w_qm[14:0];
            r_last   <= w_qb;
            r_gimbal <= r_flag[CORDIC_STAGES];
        end
    end

    assign o_out.valid          = r_vld[NSTG-1];
    assign o_out.first_angle    = r_first;
    assign o_out.middle_angle   = r_mid;
    assign o_out.last_angle     = r_last;
    assign o_out.gimbal_clamped = r_gimbal;

    a_gimbal_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.gimbal_clamped |->
            (o_out.middle_angle == 15'sd12868) || (o_out.middle_angle == -15'sd12868))
        else $error("gimbal flag without saturated middle angle");

    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.first_angle <= 16'sd25736) && (o_out.first_angle >= -16'sd25736))
        else $error("first angle out of range");

    a_last_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_angle <= 16'sd25736) && (o_out.last_angle >= -16'sd25736))
        else $error("last angle out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
endmodule

### verif/qte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_checker: Euler angle predictor and scoreboard
// Watches both channels, predicts each result from the accepted quaternion
// and the current sequence mode, and compares field by field in order.
// ----------------------------------------------------------------------------
module qte_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    qte_in_if         i_in,
    qte_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);
    import qte_pkg::*;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [14:0] middle;
        logic signed [15:0] last;
        logic               clamped;
    } t_angles;

    localparam longint ONE28 = longint'(1) << 28;
    localparam longint PI24  = 52707179;
    localparam longint HPI24 = 26353589;
    localparam int     QDEPTH = 64;

    t_angles    r_ring [0:QDEPTH-1];
    logic [5:0] r_wr_ptr;
    logic [5:0] r_rd_ptr;
    int         r_count;
    logic       mode;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lim(longint v, longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI24 : -PI24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z += longint'(atan_q24(5'(i)));
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z -= longint'(atan_q24(5'(i)));
            end
        end
        return lim(z, PI24);
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint q13(longint v);
        return (v + 1024) >>> 11;
    endfunction

    function automatic t_angles euler_of(logic m, longint w, longint x, longint y,
                                         longint z);
        longint ay, ax, by, bx, s, am, c;
        longint unsigned mag;
        t_angles r;
        if (!m) begin
            ay = 2 * (w * x + y * z);
            ax = ONE28 - 2 * (x * x + y * y);
            s  = 2 * (w * y - z * x);
            by = 2 * (w * z + x * y);
            bx = ONE28 - 2 * (y * y + z * z);
        end else begin
            ay = 2 * (w * y + z * x);
            ax = ONE28 - 2 * (y * y + x * x);
            s  = 2 * (w * z - x * y);
            by = 2 * (w * x + y * z);
            bx = ONE28 - 2 * (x * x + z * z);
        end
        r.clamped = 1'b0;
        if (s >= ONE28) begin
            am = HPI24;
            r.clamped = 1'b1;
        end else if (s <= -ONE28) begin
            am = -HPI24;
            r.clamped = 1'b1;
        end else begin
            mag = longint'(s < 0 ? -s : s);
            c = floor_sqrt((64'd1 << 56) - mag * mag);
            am = lim(vector_angle(s, c), HPI24);
        end
        r.first  = 16'(q13(vector_angle(ay, ax)));
        r.middle = 15'(q13(am));
        r.last   = 16'(q13(vector_angle(by, bx)));
        return r;
    endfunction

    assign o_pending = r_count;

    always @(posedge i_clk) begin
        t_angles exp_a;
        int      errs;
        logic    push_now;
        logic    pop_now;
        if (!i_rst_n) begin
            mode <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= 0;
            o_fail_count <= 0;
        end else begin
            errs = 0;
            push_now = i_in.valid && i_in.ready;
            pop_now = 1'b0;
            if (i_cfg_we) mode <= i_cfg_data;
            if (push_now) begin
                r_ring[r_wr_ptr] <= euler_of(mode, i_in.quat_w, i_in.quat_x,
                                             i_in.quat_y, i_in.quat_z);
                r_wr_ptr <= r_wr_ptr + 6'd1;
            end
            if (i_out.valid && i_out.ready) begin
                if (r_count == 0) begin
                    $error("unexpected result beat");
                    errs++;
                end else begin
                    pop_now = 1'b1;
                    exp_a = r_ring[r_rd_ptr];
                    r_rd_ptr <= r_rd_ptr + 6'd1;
                    if (exp_a.first !== i_out.first_angle) begin
                        $error("first_angle exp %0d got %0d", exp_a.first,
                               i_out.first_angle);
                        errs++;
                    end
                    if (exp_a.middle !== i_out.middle_angle) begin
                        $error("middle_angle exp %0d got %0d", exp_a.middle,
                               i_out.middle_angle);
                        errs++;
                    end
                    if (exp_a.last !== i_out.last_angle) begin
                        $error("last_angle exp %0d got %0d", exp_a.last,
                               i_out.last_angle);
                        errs++;
                    end
                    if (exp_a.clamped !== i_out.gimbal_clamped) begin
                        $error("gimbal_clamped exp %0d got %0d", exp_a.clamped,
                               i_out.gimbal_clamped);
                        errs++;
                    end
                end
            end
            r_count <= r_count + int'(push_now) - int'(pop_now);
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

### verif/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles: converter testbench
// Drives directed and random quaternions in both sequence modes under
// varying sender and receiver stalls; the checker scores every beat.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;

    qte_in_if  in_ch();
    qte_out_if out_ch();

    quaternion_to_euler_angles i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    qte_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.quat_w = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        out_ch.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
    end

    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.quat_w <= w;
        in_ch.quat_x <= x;
        in_ch.quat_y <= y;
        in_ch.quat_z <= z;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_and_set(logic m);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random quaternion, each component a random value in -8192..8192 scaled by 1.5
    task automatic send_unit_like();
        int a, b, c, d;
        a = $urandom_range(16384) - 8192;
        b = $urandom_range(16384) - 8192;
        c = $urandom_range(16384) - 8192;
        d = $urandom_range(16384) - 8192;
        send_quat(16'(a + a / 2), 16'(b + b / 2), 16'(c + c / 2), 16'(d + d / 2));
    endtask

    task automatic directed_set();
        send_quat(16'sd16384, 16'd0, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'd0, 16'd0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quat(16'd11585, 16'd0, 16'd11585, 16'd0);
        send_quat(16'd11585, 16'd0, -16'sd11585, 16'd0);
        send_quat(16'd11585, 16'd0, 16'd0, 16'd11585);
        send_quat(16'd11585, 16'd0, 16'd0, -16'sd11585);
        send_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
        send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
        send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
        send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
        send_quat(16'd8192, 16'd8192, 16'd8192, 16'd8192);
        send_quat(16'd8192, -16'sd8192, 16'd8192, -16'sd8192);
        send_quat(16'd11586, 16'd11, 16'd11586, -16'sd11);
        send_quat(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 2; m++) begin
            drain_and_set(m[0]);
            idle_pct = 0;
            stall_pct = 0;
            directed_set();
            for (int ph = 0; ph < 4; ph++) begin
                idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 52) : 0;
                stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 52) : 0;
                for (int k = 0; k < 45; k++) begin
                    if ($urandom_range(9) < 7)
                        send_unit_like();
                    else
                        send_quat(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                end
            end
        end
        drain_and_set(1'b0);
        idle_pct = 52;
        stall_pct = 52;
        for (int k = 0; k < 20; k++) send_unit_like();
        in_ch.valid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
